>>> sv/dtr_pkg.sv
// ----------------------------------------------------------------------------
// dtr_pkg
// Shared types and constants for the divider timer with reload: command codes,
// register addresses, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package dtr_pkg;

  // Number of low bits of the cycle count that a tick uses.
  localparam int CYCLE_WIDTH = 8;

  // Mask applied to the 8-bit cycle count field.
  localparam logic [7:0] CYCLE_MASK =
      (CYCLE_WIDTH >= 8) ? 8'hFF : 8'((1 << CYCLE_WIDTH) - 1);

  // Largest number of counter edges that one tick can produce, and its width.
  localparam int MAX_EDGES = ((1 << CYCLE_WIDTH) - 1) / 16 + 1;
  localparam int EDGE_W    = $clog2(MAX_EDGES + 1);

  // Bus addresses of the four registers.
  localparam logic [15:0] ADDR_DIV  = 16'hFF04;
  localparam logic [15:0] ADDR_TIMA = 16'hFF05;
  localparam logic [15:0] ADDR_TMA  = 16'hFF06;
  localparam logic [15:0] ADDR_TAC  = 16'hFF07;

  // Shift that counts falling edges of the selected divider bit (bit index
  // plus one), for rate selections 0 to 3: bits 9, 3, 5 and 7.
  localparam logic [3:0] EDGE_SPAN [4] = '{4'd10, 4'd4, 4'd6, 4'd8};

  // Command codes of an input transaction.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_code_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_HOLD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic step;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_done;
  } dp_stat_t;

endpackage

>>> sv/dtr_datapath.sv
// ----------------------------------------------------------------------------
// dtr_datapath
// Timer registers, edge counting and result registers. A transaction is
// executed on command, counter edges are then applied one per cycle, and
// the result is moved to the output register on command.
// ----------------------------------------------------------------------------
module dtr_datapath
  import dtr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     ctl,
  output dp_stat_t    stat,
  input  logic [1:0]  cmd,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  cycle_count,
  output logic [7:0]  read_data,
  output logic        timer_irq
);

  logic [15:0]       divider;
  logic [7:0]        tick_counter;
  logic [7:0]        reload_value;
  logic [1:0]        rate_select;
  logic              count_enable;
  logic [EDGE_W-1:0] edge_left;
  logic [7:0]        res_data;
  logic              res_irq;

  logic [16:0]       div_start;
  logic [16:0]       div_stop;
  logic [16:0]       edge_diff;
  logic [3:0]        span;
  logic [7:0]        reg_read;

  // Divider advance and the number of falling edges of the selected bit.
  always_comb begin
    span      = EDGE_SPAN[rate_select];
    div_start = {1'b0, divider};
    div_stop  = div_start + {9'b0, cycle_count & CYCLE_MASK};
    edge_diff = (div_stop >> span) - (div_start >> span);
  end

  // Register read selection.
  always_comb begin
    case (address)
      ADDR_DIV:  reg_read = divider[15:8];
      ADDR_TIMA: reg_read = tick_counter;
      ADDR_TMA:  reg_read = reload_value;
      ADDR_TAC:  reg_read = {5'b0, count_enable, rate_select};
      default:   reg_read = 8'd0;
    endcase
  end

  assign stat.count_done = (edge_left <= EDGE_W'(1));

  // Architectural state and the pending edge count.
  always_ff @(posedge clk) begin
    if (rst) begin
      divider      <= '0;
      tick_counter <= '0;
      reload_value <= '0;
      rate_select  <= '0;
      count_enable <= 1'b0;
      edge_left    <= '0;
    end else if (ctl.exec) begin
      edge_left <= '0;
      case (cmd)
        CMD_TICK: begin
          divider <= div_stop[15:0];
          if (count_enable) begin
            edge_left <= edge_diff[EDGE_W-1:0];
          end
        end
        CMD_WRITE: begin
          case (address)
            ADDR_DIV:  divider      <= '0;
            ADDR_TIMA: tick_counter <= write_data;
            ADDR_TMA:  reload_value <= write_data;
            ADDR_TAC: begin
              rate_select  <= write_data[1:0];
              count_enable <= write_data[2];
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end else if (ctl.step && (edge_left != '0)) begin
      edge_left <= edge_left - EDGE_W'(1);
      if (tick_counter == 8'hFF) begin
        tick_counter <= reload_value;
      end else begin
        tick_counter <= tick_counter + 8'd1;
      end
    end
  end

  // Result of the transaction in progress.
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      res_irq  <= 1'b0;
      res_data <= (cmd == CMD_READ) ? reg_read : 8'd0;
    end else if (ctl.step && (edge_left != '0) && (tick_counter == 8'hFF)) begin
      res_irq <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      read_data <= res_data;
      timer_irq <= res_irq;
    end
  end

endmodule

>>> sv/dtr_ctrl.sv
// ----------------------------------------------------------------------------
// dtr_ctrl
// Controller: accepts a transaction, runs the edge counting, and hands the
// result to the output register when it is free.
// ----------------------------------------------------------------------------
module dtr_ctrl
  import dtr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  ctl,
  input  dp_stat_t stat
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = (state != ST_IDLE);
    out_free   = !out_valid || !out_stall;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.exec   = 1'b1;
          state_next = ST_COUNT;
        end
      end
      ST_COUNT: begin
        ctl.step = 1'b1;
        if (stat.count_done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // The output register fills on a load and empties when taken.
  always_comb begin
    if (ctl.load_out) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // An accepted transaction always moves on to edge counting.
  a_accept_to_count: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_COUNT))
    else $error("accepted transaction did not start counting");

  // Counting ends when the datapath reports its last edge.
  a_count_to_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COUNT && stat.count_done) |=> (state == ST_HOLD))
    else $error("counting did not finish on the last edge");

  // A held result reaches an empty output register at once.
  a_hold_fills_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD && !out_valid) |=> (out_valid && state == ST_IDLE))
    else $error("held result not loaded into free output register");

  // A taken result is not presented again unless a new one is loaded.
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !ctl.load_out) |=> !out_valid)
    else $error("result presented twice");

endmodule

>>> sv/divider_timer_with_reload.sv
// ----------------------------------------------------------------------------
// divider_timer_with_reload
// Console-style timer: a free-running 16-bit divider, an 8-bit counter that
// steps on falling edges of a selected divider bit and reloads on overflow,
// and bus-addressed register access.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake             Fields
//  -------  --------------------  ------------------------------------------
//  input    in_valid / in_stall   cmd, address, write_data, cycle_count
//  output   out_valid / out_stall read_data, timer_irq
//
// A transaction passes through the idle, counting and hold states; the counting
// state applies the counter edges that a tick produces, at most 16 with an 8-bit
// cycle count, and the hold state waits for a free output register.
// The counter is stepped once per cycle by the controller's counting state.
// One finished result waits in the output register while the next
// transaction is taken. Reset is synchronous and clears all timer registers.
// in_stall is high whenever the controller is not idle.
module divider_timer_with_reload
  import dtr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  cycle_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        timer_irq
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  // Controller.
  dtr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .stat      (stat)
  );

  // Datapath.
  dtr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cmd         (cmd),
    .address     (address),
    .write_data  (write_data),
    .cycle_count (cycle_count),
    .read_data   (read_data),
    .timer_irq   (timer_irq)
  );

endmodule

>>> verif/tb_divider_timer_with_reload.sv
// ----------------------------------------------------------------------------
// tb_divider_timer_with_reload
// Self-checking bench for the console timer. A mirror of the divider, counter,
// modulo and control registers predicts the reply to every transaction that
// the block accepts, and each reply is compared with it field by field.
// Directed transactions cover resets, wraps and odd commands, then random
// traffic runs with random input gaps and random output back-pressure.
// ----------------------------------------------------------------------------
module tb_divider_timer_with_reload
  import dtr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int ITEM_TARGET = 1250;

  // Mirror of the timer registers and the replies still owed by the block.
  class timer_mirror;
    typedef struct packed {
      logic [7:0] read_data;
      logic       timer_irq;
    } reply_t;

    logic [15:0] divider;
    logic [7:0]  counter;
    logic [7:0]  modulo;
    logic [1:0]  rate;
    logic        enable;
    reply_t      pending_replies[$];
    int          errors;

    function new();
      divider = '0;
      counter = '0;
      modulo  = '0;
      rate    = '0;
      enable  = 1'b0;
      errors  = 0;
    endfunction

    // Applies one accepted transaction to the mirror and queues its reply.
    function void take_transaction(cmd_code_t op, logic [15:0] addr, logic [7:0] data,
                                   logic [7:0] cycles);
      reply_t      reply;
      logic [31:0] from_div;
      logic [31:0] to_div;
      logic [31:0] edges;
      int          span;
      reply = '0;
      case (op)
        CMD_TICK: begin
          from_div = {16'h0, divider};
          to_div   = from_div + {24'h0, cycles & CYCLE_MASK};
          if (enable) begin
            // Falling edges of the chosen divider bit, counted as if wider.
            case (rate)
              2'd0: span = 10;
              2'd1: span = 4;
              2'd2: span = 6;
              default: span = 8;
            endcase
            edges = (to_div >> span) - (from_div >> span);
            repeat (edges) begin
              if (counter == 8'hFF) begin
                counter = modulo;
                reply.timer_irq = 1'b1;
              end else begin
                counter = counter + 8'd1;
              end
            end
          end
          divider = to_div[15:0];
        end
        CMD_READ: begin
          if (addr == ADDR_DIV) reply.read_data = divider[15:8];
          else if (addr == ADDR_TIMA) reply.read_data = counter;
          else if (addr == ADDR_TMA) reply.read_data = modulo;
          else if (addr == ADDR_TAC) reply.read_data = {5'b0, enable, rate};
        end
        CMD_WRITE: begin
          if (addr == ADDR_DIV) begin
            divider = '0;
          end else if (addr == ADDR_TIMA) begin
            counter = data;
          end else if (addr == ADDR_TMA) begin
            modulo = data;
          end else if (addr == ADDR_TAC) begin
            rate   = data[1:0];
            enable = data[2];
          end
        end
        default: begin
        end
      endcase
      pending_replies.push_back(reply);
    endfunction

    // Compares one accepted reply with the oldest one owed.
    function void match_reply(logic [7:0] rd, logic irq);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("reply with none owed: read_data %0h timer_irq %0b", rd, irq);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      if (rd !== want.read_data) begin
        $error("read_data: expected %0h, actual %0h", want.read_data, rd);
        errors++;
      end
      if (irq !== want.timer_irq) begin
        $error("timer_irq: expected %0b, actual %0b", want.timer_irq, irq);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  cmd_code_t   cmd = CMD_NONE;
  logic [15:0] address = '0;
  logic [7:0]  write_data = '0;
  logic [7:0]  cycle_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data;
  logic        timer_irq;

  timer_mirror mirror = new();
  bit          calm = 1'b0;
  int          sent = 0;
  int          idle_cycles = 0;

  divider_timer_with_reload uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .address     (address),
    .write_data  (write_data),
    .cycle_count (cycle_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .timer_irq   (timer_irq)
  );

  always #5 clk = ~clk;

  // Gap length: mostly none or short, now and then long; none while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly a timer register, sometimes any address at all.
  function automatic logic [15:0] pick_address();
    if ($urandom_range(0, 9) == 0) return 16'($urandom());
    return ADDR_DIV + 16'($urandom_range(0, 3));
  endfunction

  // Presents one transaction and holds it until the block accepts it.
  task automatic send(cmd_code_t op, logic [15:0] addr, logic [7:0] data,
                      logic [7:0] cycles);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= op;
    address     <= addr;
    write_data  <= data;
    cycle_count <= cycles;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mirror.take_transaction(op, addr, data, cycles);
    sent++;
  endtask

  // Stops sending until every owed reply has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (mirror.pending_replies.size() != 0) @(posedge clk);
  endtask

  // One random transaction, weighted towards counter wraps.
  task automatic send_random();
    int          r;
    logic [15:0] addr;
    logic [7:0]  data;
    r    = $urandom_range(0, 99);
    addr = pick_address();
    data = 8'($urandom());
    if (r < 45) begin
      send(CMD_TICK, addr, data,
           ($urandom_range(0, 4) == 0) ? 8'hFF : 8'($urandom()));
    end else if (r < 70) begin
      send(CMD_READ, addr, data, 8'($urandom()));
    end else if (r < 95) begin
      if (addr == ADDR_TIMA && $urandom_range(0, 1) == 1) begin
        data = 8'($urandom_range(8'hF0, 8'hFF));
      end
      if (addr == ADDR_TAC && $urandom_range(0, 3) != 0) data = data | 8'h04;
      send(CMD_WRITE, addr, data, 8'($urandom()));
    end else begin
      send(CMD_NONE, addr, data, 8'($urandom()));
    end
  endtask

  // Receiver back-pressure: stalls of random length, none while calm.
  initial begin
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // Reply checking and the watchdog on cycles with no transaction at all.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) mirror.match_reply(read_data, timer_irq);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Main sequence: reset, directed cases, random phases, then the verdict.
  initial begin
    int phase;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Registers straight after reset.
    send(CMD_READ, ADDR_DIV, 8'h00, 8'h00);
    send(CMD_READ, ADDR_TIMA, 8'h00, 8'h00);
    send(CMD_READ, ADDR_TMA, 8'h00, 8'h00);
    send(CMD_READ, ADDR_TAC, 8'h00, 8'h00);
    // Counter wrap with reload, at the fastest rate and the longest tick.
    send(CMD_WRITE, ADDR_TMA, 8'hAB, 8'h00);
    send(CMD_WRITE, ADDR_TIMA, 8'hFE, 8'h00);
    send(CMD_WRITE, ADDR_TAC, 8'h05, 8'h00);
    send(CMD_TICK, 16'h0000, 8'h00, 8'hFF);
    send(CMD_READ, ADDR_TIMA, 8'h00, 8'h00);
    send(CMD_TICK, 16'hFFFF, 8'hFF, 8'h00);
    // Counting disabled while the divider keeps running.
    send(CMD_WRITE, ADDR_TAC, 8'hFB, 8'hFF);
    send(CMD_TICK, ADDR_TAC, 8'h00, 8'hFF);
    send(CMD_READ, ADDR_TAC, 8'h00, 8'h00);
    // Remaining rates.
    send(CMD_WRITE, ADDR_TAC, 8'h06, 8'h00);
    send(CMD_TICK, 16'h0000, 8'h00, 8'hC0);
    send(CMD_WRITE, ADDR_TAC, 8'hFC, 8'h00);
    send(CMD_TICK, 16'h0000, 8'h00, 8'hFF);
    send(CMD_READ, ADDR_DIV, 8'h00, 8'h00);
    // Divider clear, unknown addresses and the unused command.
    send(CMD_WRITE, ADDR_DIV, 8'h5A, 8'h00);
    send(CMD_READ, ADDR_DIV, 8'h00, 8'h00);
    send(CMD_WRITE, 16'h0000, 8'hFF, 8'hFF);
    send(CMD_READ, 16'hFF03, 8'h00, 8'h00);
    send(CMD_READ, 16'hFF08, 8'h00, 8'h00);
    send(CMD_NONE, ADDR_TIMA, 8'hFF, 8'hFF);
    drain();

    // Random phases; one long run of ticks carries the divider past its wrap.
    phase = 0;
    while (sent < ITEM_TARGET) begin
      calm = (phase % 4 == 0);
      if (phase == 2) begin
        calm = 1'b1;
        send(CMD_WRITE, ADDR_TAC, 8'h04, 8'h00);
        send(CMD_WRITE, ADDR_TIMA, 8'($urandom()), 8'h00);
        repeat (310) send(CMD_TICK, pick_address(), 8'($urandom()),
                          8'($urandom_range(200, 255)));
        send(CMD_READ, ADDR_TIMA, 8'h00, 8'h00);
      end else begin
        repeat (60) send_random();
      end
      drain();
      phase++;
    end
    calm = 1'b0;

    // Let the block settle, then give the verdict.
    repeat (40) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
